### hdl/hhfc_pkg.sv
// Shared types, constants and helper functions for the HTTP header framing check.
`timescale 1ns / 1ps

package hhfc_pkg;

    localparam int HEADER_COUNT_BITS = 17;
    localparam int BYTE_COUNT_BITS = 32;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] MAX_HEADER_RESET = 16'd8192;
    localparam logic [31:0] MAX_BODY_RESET = 32'd1048576;

    localparam logic [3:0] KEY_LEN = 4'd14;
    localparam logic [63:0] ACC_LIMIT = 64'h1999_9999_9999_9999;
    localparam logic [3:0] ACC_LIMIT_DIGIT = 4'd5;

    localparam logic [7:0] ASCII_TAB = 8'h09;
    localparam logic [7:0] ASCII_LF = 8'h0A;
    localparam logic [7:0] ASCII_CR = 8'h0D;
    localparam logic [7:0] ASCII_SPACE = 8'h20;
    localparam logic [7:0] ASCII_PLUS = 8'h2B;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;
    localparam logic [7:0] ASCII_COLON = 8'h3A;
    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [7:0] ASCII_CASE_STEP = 8'h20;

    typedef enum logic [1:0] {
        STATUS_INCOMPLETE = 2'd0,
        STATUS_COMPLETE   = 2'd1,
        STATUS_BAD        = 2'd2,
        STATUS_TOO_LARGE  = 2'd3
    } status_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_MAX_HEADER = 1'b0,
        REG_MAX_BODY   = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        PH_REQUEST    = 3'd0,
        PH_LEAD       = 3'd1,
        PH_NAME       = 3'd2,
        PH_NAME_TRAIL = 3'd3,
        PH_VALUE      = 3'd4
    } line_phase_t;

    typedef enum logic [2:0] {
        VP_AWAIT  = 3'd0,
        VP_SIGN   = 3'd1,
        VP_DIGITS = 3'd2,
        VP_TRAIL  = 3'd3,
        VP_BAD    = 3'd4
    } value_phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_item_t;

    typedef struct packed {
        status_t     status;
        logic [32:0] expected_length;
    } result_item_t;

    // Summary of one finished buffer, handed from the parser to the decision stage.
    typedef struct packed {
        logic                         headers_ended;
        logic                         length_invalid;
        logic                         length_high;
        logic [31:0]                  length_low;
        logic [BYTE_COUNT_BITS-1:0]   byte_count;
        logic [HEADER_COUNT_BITS-1:0] header_length;
    } frame_rec_t;

    typedef struct packed {
        line_phase_t  phase;
        logic [3:0]   match_index;
        logic         name_hit;
        value_phase_t value_phase;
        logic [63:0]  accumulator;
        logic         negative;
    } line_state_t;

    function automatic logic [7:0] key_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h63;
            4'd1:    c = 8'h6F;
            4'd2:    c = 8'h6E;
            4'd3:    c = 8'h74;
            4'd4:    c = 8'h65;
            4'd5:    c = 8'h6E;
            4'd6:    c = 8'h74;
            4'd7:    c = 8'h2D;
            4'd8:    c = 8'h6C;
            4'd9:    c = 8'h65;
            4'd10:   c = 8'h6E;
            4'd11:   c = 8'h67;
            4'd12:   c = 8'h74;
            4'd13:   c = 8'h68;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_ws(input logic [7:0] b);
        return (b == ASCII_SPACE) || ((b >= ASCII_TAB) && (b <= ASCII_CR));
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        return ((b >= ASCII_UPPER_A) && (b <= ASCII_UPPER_Z)) ? b + ASCII_CASE_STEP : b;
    endfunction

endpackage

### hdl/hhfc_front.sv
// Byte parser: tracks the header terminator, line structure and Content-Length values.
`timescale 1ns / 1ps

module hhfc_front
    import hhfc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  byte_item_t byte_item,
    output logic       push,
    output frame_rec_t push_data,
    input  logic       queue_full
);

    localparam logic [BYTE_COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [HEADER_COUNT_BITS-1:0] HEADER_MAX = '1;

    logic [BYTE_COUNT_BITS-1:0]   byte_count_reg, byte_count_next;
    logic [1:0]                   term_reg, term_next;
    logic                         ended_reg, ended_next;
    logic [HEADER_COUNT_BITS-1:0] header_length_reg, header_length_next;
    line_state_t                  line_reg, line_next;
    logic [63:0]                  content_reg, content_next;
    logic                         invalid_reg, invalid_next;
    logic                         pend_cr_reg, pend_cr_next;
    logic                         accept;
    logic [7:0]                   b;

    function automatic line_state_t line_reset();
        line_state_t r;
        r.phase = PH_LEAD;
        r.match_index = 4'd0;
        r.name_hit = 1'b1;
        r.value_phase = VP_AWAIT;
        r.accumulator = 64'd0;
        r.negative = 1'b0;
        return r;
    endfunction

    function automatic line_state_t add_digit(input line_state_t s, input logic [3:0] d);
        line_state_t r;
        r = s;
        if ((s.accumulator > ACC_LIMIT) || ((s.accumulator == ACC_LIMIT) && (d > ACC_LIMIT_DIGIT)))
        begin
            r.value_phase = VP_BAD;
        end
        else
        begin
            r.accumulator = (s.accumulator << 3) + (s.accumulator << 1) + {60'd0, d};
            r.value_phase = VP_DIGITS;
        end
        return r;
    endfunction

    function automatic line_state_t value_step(input line_state_t s, input logic [7:0] c);
        line_state_t r;
        logic dig;
        r = s;
        dig = (c >= ASCII_ZERO) && (c <= ASCII_NINE);
        case (s.value_phase)
            VP_AWAIT:
            begin
                if (is_ws(c))
                begin
                    r = s;
                end
                else if (c == ASCII_PLUS)
                begin
                    r.value_phase = VP_SIGN;
                end
                else if (c == ASCII_MINUS)
                begin
                    r.negative = 1'b1;
                    r.value_phase = VP_SIGN;
                end
                else if (dig)
                begin
                    r = add_digit(s, c[3:0]);
                end
                else
                begin
                    r.value_phase = VP_BAD;
                end
            end
            VP_SIGN:
            begin
                if (dig)
                begin
                    r = add_digit(s, c[3:0]);
                end
                else
                begin
                    r.value_phase = VP_BAD;
                end
            end
            VP_DIGITS:
            begin
                if (dig)
                begin
                    r = add_digit(s, c[3:0]);
                end
                else if (is_ws(c))
                begin
                    r.value_phase = VP_TRAIL;
                end
                else
                begin
                    r.value_phase = VP_BAD;
                end
            end
            VP_TRAIL:
            begin
                if (!is_ws(c))
                begin
                    r.value_phase = VP_BAD;
                end
            end
            default:
            begin
                r.value_phase = VP_BAD;
            end
        endcase
        return r;
    endfunction

    function automatic line_state_t compare_name(input line_state_t s, input logic [7:0] c);
        line_state_t r;
        r = s;
        if ((s.match_index < KEY_LEN) && (to_lower(c) == key_char(s.match_index)))
        begin
            r.match_index = s.match_index + 4'd1;
        end
        else
        begin
            r.name_hit = 1'b0;
        end
        return r;
    endfunction

    function automatic line_state_t content_step(input line_state_t s, input logic [7:0] c);
        line_state_t r;
        r = s;
        case (s.phase)
            PH_REQUEST:
            begin
                r = s;
            end
            PH_VALUE:
            begin
                r = value_step(s, c);
            end
            default:
            begin
                if (c == ASCII_COLON)
                begin
                    r.name_hit = s.name_hit && (s.match_index == KEY_LEN);
                    r.phase = PH_VALUE;
                end
                else if (s.phase == PH_LEAD)
                begin
                    if (!is_ws(c))
                    begin
                        r.phase = PH_NAME;
                        r = compare_name(r, c);
                    end
                end
                else if (s.phase == PH_NAME)
                begin
                    if (is_ws(c))
                    begin
                        r.phase = PH_NAME_TRAIL;
                    end
                    else
                    begin
                        r = compare_name(r, c);
                    end
                end
                else if (!is_ws(c))
                begin
                    r.name_hit = 1'b0;
                end
            end
        endcase
        return r;
    endfunction

    assign byte_stall = queue_full;
    assign accept = byte_valid && !queue_full;
    assign b = byte_item.data_byte;

    always_comb
    begin
        byte_count_next = (byte_count_reg != COUNT_MAX) ? byte_count_reg + 1'b1 : byte_count_reg;
        term_next = term_reg;
        ended_next = ended_reg;
        header_length_next = header_length_reg;
        line_next = line_reg;
        content_next = content_reg;
        invalid_next = invalid_reg;
        pend_cr_next = pend_cr_reg;

        if (!ended_reg)
        begin
            if (pend_cr_reg)
            begin
                if (b == ASCII_LF)
                begin
                    pend_cr_next = 1'b0;
                    if ((line_reg.phase == PH_VALUE) && line_reg.name_hit)
                    begin
                        if ((line_reg.value_phase == VP_DIGITS) ||
                            (line_reg.value_phase == VP_TRAIL))
                        begin
                            content_next = line_reg.negative ? 64'd0 - line_reg.accumulator
                                                             : line_reg.accumulator;
                        end
                        else
                        begin
                            invalid_next = 1'b1;
                        end
                    end
                    line_next = line_reset();
                end
                else
                begin
                    line_next = content_step(line_reg, ASCII_CR);
                    if (b != ASCII_CR)
                    begin
                        pend_cr_next = 1'b0;
                        line_next = content_step(line_next, b);
                    end
                end
            end
            else if (b == ASCII_CR)
            begin
                pend_cr_next = 1'b1;
            end
            else
            begin
                line_next = content_step(line_reg, b);
            end

            if (b == ASCII_CR)
            begin
                term_next = (term_reg == 2'd2) ? 2'd3 : 2'd1;
            end
            else if ((b == ASCII_LF) && (term_reg == 2'd1))
            begin
                term_next = 2'd2;
            end
            else if ((b == ASCII_LF) && (term_reg == 2'd3))
            begin
                term_next = 2'd0;
                ended_next = 1'b1;
                header_length_next = ((byte_count_next >> HEADER_COUNT_BITS) != '0)
                                     ? HEADER_MAX
                                     : byte_count_next[HEADER_COUNT_BITS-1:0];
            end
            else
            begin
                term_next = 2'd0;
            end
        end
    end

    assign push = accept && byte_item.last_byte;

    always_comb
    begin
        push_data.headers_ended = ended_next;
        push_data.length_invalid = invalid_next;
        push_data.length_high = |content_next[63:32];
        push_data.length_low = content_next[31:0];
        push_data.byte_count = byte_count_next;
        push_data.header_length = header_length_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            term_reg <= 2'd0;
            ended_reg <= 1'b0;
            header_length_reg <= '0;
            line_reg <= '{PH_REQUEST, 4'd0, 1'b1, VP_AWAIT, 64'd0, 1'b0};
            content_reg <= 64'd0;
            invalid_reg <= 1'b0;
            pend_cr_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (byte_item.last_byte)
            begin
                byte_count_reg <= '0;
                term_reg <= 2'd0;
                ended_reg <= 1'b0;
                header_length_reg <= '0;
                line_reg <= '{PH_REQUEST, 4'd0, 1'b1, VP_AWAIT, 64'd0, 1'b0};
                content_reg <= 64'd0;
                invalid_reg <= 1'b0;
                pend_cr_reg <= 1'b0;
            end
            else
            begin
                byte_count_reg <= byte_count_next;
                term_reg <= term_next;
                ended_reg <= ended_next;
                header_length_reg <= header_length_next;
                line_reg <= line_next;
                content_reg <= content_next;
                invalid_reg <= invalid_next;
                pend_cr_reg <= pend_cr_next;
            end
        end
    end

endmodule

### hdl/hhfc_queue.sv
// Short queue of finished buffer summaries between the parser and the decision stage.
`timescale 1ns / 1ps

module hhfc_queue
    import hhfc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  frame_rec_t push_data,
    output logic       full,
    input  logic       pop,
    output logic       head_valid,
    output frame_rec_t head_data
);

    localparam logic [QUEUE_PTR_BITS-1:0] PTR_LAST = QUEUE_PTR_BITS'(QUEUE_DEPTH - 1);
    localparam logic [QUEUE_COUNT_BITS-1:0] COUNT_FULL = QUEUE_COUNT_BITS'(QUEUE_DEPTH);

    frame_rec_t                  entries_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_COUNT_BITS-1:0] count_reg, count_next;
    logic                        do_push, do_pop;

    assign full = (count_reg == COUNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_data = entries_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hdl/hhfc_back.sv
// Decision stage: holds the size limits and turns a buffer summary into a status item.
`timescale 1ns / 1ps

module hhfc_back
    import hhfc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      head_valid,
    input  frame_rec_t                head_data,
    output logic                      pop,
    output logic                      result_valid,
    input  logic                      result_stall,
    output result_item_t              result_item
);

    logic [15:0]  max_header_reg;
    logic [31:0]  max_body_reg;
    logic         out_valid_reg, out_valid_next;
    result_item_t out_item_reg, out_item_next;
    logic [32:0]  header_wide, max_header_wide, count_wide, expected;

    assign pop = head_valid && (!out_valid_reg || !result_stall);
    assign result_valid = out_valid_reg;
    assign result_item = out_item_reg;

    assign header_wide = 33'(head_data.header_length);
    assign max_header_wide = 33'(max_header_reg);
    assign count_wide = 33'(head_data.byte_count);
    assign expected = header_wide + 33'(head_data.length_low);

    always_comb
    begin
        out_item_next.status = STATUS_INCOMPLETE;
        out_item_next.expected_length = 33'd0;
        if (!head_data.headers_ended)
        begin
            out_item_next.status = (count_wide > max_header_wide) ? STATUS_TOO_LARGE
                                                                   : STATUS_INCOMPLETE;
        end
        else if (header_wide > max_header_wide)
        begin
            out_item_next.status = STATUS_TOO_LARGE;
        end
        else if (head_data.length_invalid)
        begin
            out_item_next.status = STATUS_BAD;
        end
        else if (head_data.length_high || (head_data.length_low > max_body_reg))
        begin
            out_item_next.status = STATUS_TOO_LARGE;
        end
        else
        begin
            out_item_next.expected_length = expected;
            out_item_next.status = (count_wide >= expected) ? STATUS_COMPLETE
                                                            : STATUS_INCOMPLETE;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_header_reg <= MAX_HEADER_RESET;
            max_body_reg <= MAX_BODY_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_MAX_HEADER: max_header_reg <= cfg_data[15:0];
                    REG_MAX_BODY:   max_body_reg <= cfg_data[31:0];
                    default:        max_body_reg <= max_body_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_item_reg <= out_item_next;
        end
    end

endmodule

### hdl/http_header_framing_check.sv
// Top level of the HTTP header framing check: parser, summary queue and decision stage.
// Throughput: one byte item per cycle while the summary queue is not full, with no gaps between buffers.
// The summary of a last-marked byte enters the queue when the byte is accepted, and its result item is
// registered in the decision stage's output register when that entry is popped from the queue.
// The parser stalls only while the two-entry summary queue is full.
// Reset (rst_n low, asynchronous) clears all parse state and loads the default limits.
`timescale 1ns / 1ps

module http_header_framing_check
    import hhfc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      byte_valid,
    output logic                      byte_stall,
    input  byte_item_t                byte_item,
    output logic                      result_valid,
    input  logic                      result_stall,
    output result_item_t              result_item
);

    logic       push, queue_full, pop, head_valid;
    frame_rec_t push_data, head_data;

    hhfc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .push       (push),
        .push_data  (push_data),
        .queue_full (queue_full)
    );

    hhfc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    hhfc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .head_valid   (head_valid),
        .head_data    (head_data),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

endmodule

### tb/testbench.sv
// Self-checking testbench for the HTTP header framing check, driven with request byte streams.
`timescale 1ns / 1ps

module testbench;
    import hhfc_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_BYTES = 175;
    localparam logic [63:0] MUL10_LIMIT = 64'h1999_9999_9999_9999;
    localparam logic [8*14-1:0] LENGTH_KEY = "content-length";
    localparam logic [HEADER_COUNT_BITS-1:0] HDR_LEN_MAX = '1;

    logic clk;
    logic rst_n = 1'b0;
    logic cfg_write_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;
    logic byte_valid = 1'b0;
    logic byte_stall;
    byte_item_t byte_item = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    result_item_t result_item;

    byte_item_t pending_bytes[$];
    result_item_t expected_results[$];
    result_item_t want_result;
    logic [7:0] frame_bytes[$];
    int sender_idle_pct;
    int receiver_idle_pct;
    int bytes_queued;
    int planned_body;
    int errors;
    logic hold_armed = 1'b0;
    int hold_count;
    logic long_hold;

    // Predictor state.
    logic [15:0] lim_hdr;
    logic [31:0] lim_body;
    logic [31:0] cnt_bytes;
    logic [1:0] crlf_seen;
    logic hdr_done;
    logic [HEADER_COUNT_BITS-1:0] hdr_len;
    line_phase_t lphase;
    logic [3:0] key_pos;
    logic key_ok;
    value_phase_t vphase;
    logic [63:0] acc;
    logic neg;
    logic [63:0] clen;
    logic clen_bad;
    logic cr_held;

    http_header_framing_check dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write_en(cfg_write_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .byte_valid(byte_valid),
        .byte_stall(byte_stall),
        .byte_item(byte_item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result_item(result_item)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic logic is_blank(input logic [7:0] b);
        return (b == " ") || ((b >= 8'h09) && (b <= 8'h0D));
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] b);
        return ((b >= "A") && (b <= "Z")) ? b + 8'd32 : b;
    endfunction

    function void clear_line();
        lphase = PH_LEAD;
        key_pos = '0;
        key_ok = 1'b1;
        vphase = VP_AWAIT;
        acc = '0;
        neg = 1'b0;
    endfunction

    function void clear_frame();
        cnt_bytes = '0;
        crlf_seen = '0;
        hdr_done = 1'b0;
        hdr_len = '0;
        clen = '0;
        clen_bad = 1'b0;
        cr_held = 1'b0;
        clear_line();
        lphase = PH_REQUEST;
    endfunction

    function void match_name(input logic [7:0] b);
        if ((key_pos < 4'd14) && (fold_case(b) == LENGTH_KEY[8 * (13 - int'(key_pos)) +: 8]))
        begin
            key_pos = key_pos + 4'd1;
        end
        else
        begin
            key_ok = 1'b0;
        end
    endfunction

    function void take_digit(input logic [7:0] d);
        if ((acc > MUL10_LIMIT) || ((acc == MUL10_LIMIT) && (d > 8'd5)))
        begin
            vphase = VP_BAD;
        end
        else
        begin
            acc = acc * 64'd10 + 64'(d);
            vphase = VP_DIGITS;
        end
    endfunction

    function void value_char(input logic [7:0] b);
        logic digit;
        digit = (b >= "0") && (b <= "9");
        case (vphase)
            VP_AWAIT:
            begin
                if (is_blank(b))
                begin
                    vphase = VP_AWAIT;
                end
                else if (b == "+")
                begin
                    vphase = VP_SIGN;
                end
                else if (b == "-")
                begin
                    neg = 1'b1;
                    vphase = VP_SIGN;
                end
                else if (digit)
                begin
                    take_digit(b - "0");
                end
                else
                begin
                    vphase = VP_BAD;
                end
            end
            VP_SIGN:
            begin
                if (digit)
                begin
                    take_digit(b - "0");
                end
                else
                begin
                    vphase = VP_BAD;
                end
            end
            VP_DIGITS:
            begin
                if (digit)
                begin
                    take_digit(b - "0");
                end
                else if (is_blank(b))
                begin
                    vphase = VP_TRAIL;
                end
                else
                begin
                    vphase = VP_BAD;
                end
            end
            VP_TRAIL:
            begin
                if (!is_blank(b))
                begin
                    vphase = VP_BAD;
                end
            end
            default:
            begin
                vphase = VP_BAD;
            end
        endcase
    endfunction

    function void content_char(input logic [7:0] b);
        if (lphase == PH_REQUEST)
        begin
            return;
        end
        if (lphase == PH_VALUE)
        begin
            value_char(b);
            return;
        end
        if (b == ":")
        begin
            key_ok = key_ok && (key_pos == 4'd14);
            lphase = PH_VALUE;
            return;
        end
        case (lphase)
            PH_LEAD:
            begin
                if (!is_blank(b))
                begin
                    lphase = PH_NAME;
                    match_name(b);
                end
            end
            PH_NAME:
            begin
                if (is_blank(b))
                begin
                    lphase = PH_NAME_TRAIL;
                end
                else
                begin
                    match_name(b);
                end
            end
            default:
            begin
                if (!is_blank(b))
                begin
                    key_ok = 1'b0;
                end
            end
        endcase
    endfunction

    function void close_line();
        if ((lphase == PH_VALUE) && key_ok)
        begin
            if ((vphase == VP_DIGITS) || (vphase == VP_TRAIL))
            begin
                clen = neg ? (64'd0 - acc) : acc;
            end
            else
            begin
                clen_bad = 1'b1;
            end
        end
        clear_line();
    endfunction

    function void line_char(input logic [7:0] b);
        if (cr_held)
        begin
            if (b == "\n")
            begin
                cr_held = 1'b0;
                close_line();
            end
            else
            begin
                content_char("\r");
                if (b != "\r")
                begin
                    cr_held = 1'b0;
                    content_char(b);
                end
            end
        end
        else if (b == "\r")
        begin
            cr_held = 1'b1;
        end
        else
        begin
            content_char(b);
        end
    endfunction

    // Advances the frame state by one accepted byte; a last-marked byte yields one result.
    function void predict_byte(input byte_item_t it);
        logic [63:0] total;
        status_t st;
        if (cnt_bytes != '1)
        begin
            cnt_bytes = cnt_bytes + 32'd1;
        end
        if (!hdr_done)
        begin
            line_char(it.data_byte);
            if (it.data_byte == "\r")
            begin
                crlf_seen = (crlf_seen == 2'd2) ? 2'd3 : 2'd1;
            end
            else if ((it.data_byte == "\n") && (crlf_seen == 2'd1))
            begin
                crlf_seen = 2'd2;
            end
            else if ((it.data_byte == "\n") && (crlf_seen == 2'd3))
            begin
                crlf_seen = 2'd0;
                hdr_done = 1'b1;
                hdr_len = (cnt_bytes > HDR_LEN_MAX) ? HDR_LEN_MAX
                                                    : cnt_bytes[HEADER_COUNT_BITS-1:0];
            end
            else
            begin
                crlf_seen = 2'd0;
            end
        end
        if (!it.last_byte)
        begin
            return;
        end
        total = '0;
        if (!hdr_done)
        begin
            st = (cnt_bytes > lim_hdr) ? STATUS_TOO_LARGE : STATUS_INCOMPLETE;
        end
        else if (hdr_len > lim_hdr)
        begin
            st = STATUS_TOO_LARGE;
        end
        else if (clen_bad)
        begin
            st = STATUS_BAD;
        end
        else if (clen > lim_body)
        begin
            st = STATUS_TOO_LARGE;
        end
        else
        begin
            total = 64'(hdr_len) + clen;
            st = (64'(cnt_bytes) >= total) ? STATUS_COMPLETE : STATUS_INCOMPLETE;
        end
        expected_results.push_back('{status: st, expected_length: total[32:0]});
        clear_frame();
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
        end
        else
        begin
            if (byte_valid && !byte_stall)
            begin
                predict_byte(byte_item);
            end
            if (!byte_valid || !byte_stall)
            begin
                if ((pending_bytes.size() > 0) && ($urandom_range(0, 99) >= sender_idle_pct))
                begin
                    byte_valid <= 1'b1;
                    byte_item <= pending_bytes.pop_front();
                end
                else
                begin
                    byte_valid <= 1'b0;
                end
            end
        end
    end

    assign long_hold = hold_armed && (hold_count < HOLD_CYCLES);

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_count <= 0;
        end
        else if (long_hold)
        begin
            hold_count <= hold_count + 1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result item: status %0d expected_length %0d",
                           result_item.status, result_item.expected_length);
                    errors++;
                end
                else
                begin
                    want_result = expected_results.pop_front();
                    if (result_item.status !== want_result.status)
                    begin
                        $error("status: expected %0d, actual %0d",
                               want_result.status, result_item.status);
                        errors++;
                    end
                    if (result_item.expected_length !== want_result.expected_length)
                    begin
                        $error("expected_length: expected %0d, actual %0d",
                               want_result.expected_length, result_item.expected_length);
                        errors++;
                    end
                end
            end
            result_stall <= long_hold || ($urandom_range(0, 99) < receiver_idle_pct);
        end
    end

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            frame_bytes.push_back(s[i]);
        end
    endtask

    task automatic add_blanks();
        int n;
        n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
        repeat (n)
        begin
            case ($urandom_range(0, 5))
                0: frame_bytes.push_back(8'h09);
                1: frame_bytes.push_back(8'h0B);
                2: frame_bytes.push_back(8'h0C);
                3: frame_bytes.push_back(8'h0A);
                default: frame_bytes.push_back(" ");
            endcase
        end
    endtask

    task automatic add_random_bytes(input int n);
        repeat (n)
        begin
            frame_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    function automatic string number_text();
        int v;
        case ($urandom_range(0, 11))
            0, 1, 2, 3, 4, 5:
            begin
                v = $urandom_range(0, 40);
                planned_body = v;
                return $sformatf("%0d", v);
            end
            6: return $sformatf("%0d", $urandom);
            7: return $sformatf("%0d", {$urandom, $urandom});
            8: return "18446744073709551615";
            9: return ($urandom_range(0, 1) == 0) ? "18446744073709551616"
                                                  : "9999999999999999999999";
            10:
            begin
                v = $urandom_range(0, 40);
                planned_body = v;
                return {"000", $sformatf("%0d", v)};
            end
            default: return "";
        endcase
    endfunction

    task automatic add_length_header();
        string name;
        logic [7:0] c;
        name = "Content-Length";
        if ($urandom_range(0, 5) == 0)
        begin
            case ($urandom_range(0, 4))
                0: name = "Content-Lengt";
                1: name = "Content-Lengthh";
                2: name = "Content Length";
                3: name = "Content-Length-X";
                default: name = "xContent-Length";
            endcase
        end
        add_blanks();
        for (int i = 0; i < name.len(); i++)
        begin
            c = name[i];
            if ($urandom_range(0, 1) == 1)
            begin
                if ((c >= "a") && (c <= "z"))
                begin
                    c = c - 8'd32;
                end
                else if ((c >= "A") && (c <= "Z"))
                begin
                    c = c + 8'd32;
                end
            end
            frame_bytes.push_back(c);
        end
        add_blanks();
        if ($urandom_range(0, 19) == 0)
        begin
            add_text("x");
        end
        add_text(":");
        add_blanks();
        case ($urandom_range(0, 9))
            8: add_text("+");
            9: add_text("-");
            default: ;
        endcase
        add_text(number_text());
        add_blanks();
        if ($urandom_range(0, 14) == 0)
        begin
            add_text(($urandom_range(0, 1) == 0) ? "x" : ";q");
        end
        add_text("\r\n");
    endtask

    task automatic add_other_line();
        case ($urandom_range(0, 3))
            0: add_text("Host: example.test\r\n");
            1: add_text("Accept:*/*\r\n");
            2: add_text("NoColonHere\r\n");
            default:
            begin
                add_random_bytes($urandom_range(1, 12));
                add_text("\r\n");
            end
        endcase
    endtask

    task automatic send_frame();
        byte_item_t it;
        foreach (frame_bytes[i])
        begin
            it.data_byte = frame_bytes[i];
            it.last_byte = (i == frame_bytes.size() - 1);
            pending_bytes.push_back(it);
        end
        bytes_queued += frame_bytes.size();
        frame_bytes.delete();
    endtask

    task automatic make_request();
        int kind;
        int body;
        frame_bytes.delete();
        planned_body = -1;
        kind = $urandom_range(0, 99);
        if (kind < 6)
        begin
            add_random_bytes($urandom_range(1, 30));
        end
        else if (kind < 11)
        begin
            add_text("\r\n\r\n");
            add_random_bytes($urandom_range(0, 3));
        end
        else
        begin
            add_text(($urandom_range(0, 2) == 0) ? "POST /x HTTP/1.1\r\n" : "GET / HTTP/1.1\r\n");
            repeat ($urandom_range(0, 4))
            begin
                if ($urandom_range(0, 9) < 5)
                begin
                    add_length_header();
                end
                else
                begin
                    add_other_line();
                end
            end
            add_text("\r\n");
            if ((planned_body >= 0) && ($urandom_range(0, 3) != 0))
            begin
                body = planned_body + $urandom_range(0, 2) - 1;
                body = (body < 0) ? 0 : body;
            end
            else
            begin
                body = $urandom_range(0, 6);
            end
            add_random_bytes(body);
            if ($urandom_range(0, 9) == 0)
            begin
                frame_bytes = frame_bytes[0:$urandom_range(0, frame_bytes.size() - 1)];
            end
        end
        send_frame();
    endtask

    task automatic program_limits(input logic [15:0] hdr, input logic [31:0] body);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= REG_MAX_HEADER;
        cfg_data <= {16'd0, hdr};
        @(posedge clk);
        cfg_index <= REG_MAX_BODY;
        cfg_data <= body;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        lim_hdr = hdr;
        lim_body = body;
    endtask

    task automatic wait_drained();
        while ((pending_bytes.size() != 0) || byte_valid || (expected_results.size() != 0))
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        #4_000_000;
        $display("FAIL http_header_framing_check");
        $finish;
    end

    initial
    begin
        logic [15:0] hdr_setting[6];
        logic [31:0] body_setting[6];
        int target;
        hdr_setting = '{16'd8192, 16'd4, 16'd65535, 16'd40, 16'd0, 16'd100};
        body_setting = '{32'd1048576, 32'd0, 32'hFFFF_FFFF, 32'd20, 32'd0, 32'd30};
        hdr_setting[4] = 16'($urandom_range(4, 120));
        body_setting[4] = $urandom_range(0, 60);
        errors = 0;
        bytes_queued = 0;
        sender_idle_pct = 17;
        receiver_idle_pct = 48;
        lim_hdr = MAX_HEADER_RESET;
        lim_body = MAX_BODY_RESET;
        clear_frame();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < 6; ph++)
        begin
            sender_idle_pct = (ph < 2) ? 17 : (ph < 4) ? 48 : 0;
            receiver_idle_pct = (ph < 2) ? 48 : (ph < 4) ? 17 : 0;
            program_limits(hdr_setting[ph], body_setting[ph]);
            if (ph == 0)
            begin
                add_text("X");
                send_frame();
                add_text("\r\n\r\n");
                send_frame();
                add_text("R\r\ncontent-LENGTH :\t+7 \r\n\r\n1234567");
                send_frame();
                add_text("R\r\nContent-Length: -1\r\n\r\n");
                send_frame();
                add_text("R\r\nContent-Length:18446744073709551616\r\n\r\n");
                send_frame();
                add_text("\r\nContent-Length:\r\nContent-Length: 3\r\n\r\n");
                send_frame();
                add_text("R\r\nContent-Length: -\r\nA:1\r\n\r\n");
                send_frame();
                add_text("R\r\nContent-Length: 12x\r\n\r\n");
                send_frame();
                // Lone CR, lone LF and NUL inside a header line are plain content.
                add_text("R\r\nA\rB\nC");
                frame_bytes.push_back(8'h00);
                add_text("\r\r\nContent-Length: 2\r\n\r\nabcdef");
                send_frame();
            end
            if (ph == 5)
            begin
                hold_armed <= 1'b1;
            end
            target = bytes_queued + PHASE_BYTES;
            while (bytes_queued < target)
            begin
                make_request();
            end
            wait_drained();
        end

        if (errors == 0)
        begin
            $display("PASS http_header_framing_check");
        end
        else
        begin
            $display("FAIL http_header_framing_check");
        end
        $finish;
    end

endmodule
